/* design/grid_neighbor_cell_enumerator_assert.svh */
// Assertion macros for the grid neighbour enumerator.
// Included by the top level; no other dependencies.
`ifndef GRID_NEIGHBOR_CELL_ENUMERATOR_ASSERT_SVH
`define GRID_NEIGHBOR_CELL_ENUMERATOR_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define GNCE_ASSERT_IMPL(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gnce assertion failed");
// next-cycle implication
`define GNCE_ASSERT_NEXT(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gnce assertion failed");
`else
`define GNCE_ASSERT_IMPL(label, clk_s, rst_n, ante, cons)
`define GNCE_ASSERT_NEXT(label, clk_s, rst_n, ante, cons)
`endif

`endif

/* design/gnce_pkg.sv */
// Shared types and constants of the grid neighbour enumerator.
// No dependencies.
package gnce_pkg;

	localparam int IDX_W       = 18;
	localparam int SIZE_W      = 7;
	localparam int MAX_DIM_DEF = 64;
	localparam int DIM_W_DEF   = 7;
	localparam int QUEUE_DEPTH = 2;
	localparam int OUT_DEPTH   = 2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd16;

	// register indexes
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

	// cycles that input is held off after a register write
	localparam logic [1:0] CFG_SETTLE = 2'd2;

	typedef enum logic [1:0] {
		OFS_NEG,
		OFS_MID,
		OFS_POS
	} ofs_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_DIV_Z,
		FS_DIV_Y,
		FS_EMIT
	} front_state_t;

	// classified query, front to back
	typedef struct packed {
		logic [IDX_W-1:0] cell_idx;
		logic             oob;
		logic             lo_x;
		logic             hi_x;
		logic             lo_y;
		logic             hi_y;
		logic             lo_z;
		logic             hi_z;
	} job_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             valid;
		logic             last;
	} res_t;

endpackage

/* design/grid_neighbor_cell_enumerator.sv */
// Top level of the 3D grid neighbour cell enumerator.
// Depends on gnce_pkg, gnce_fifo, gnce_front, gnce_back and the assertion header.
//
// Give it a linear cell index (x + y*size_x + z*size_x*size_y) and it returns
// the linear index of every in-grid cell of the 3x3x3 block around it, the
// cell itself included, in offset order X outermost, Z innermost, with last
// set on the final one. An index at or beyond the grid total gives a single
// result with valid_res low, index zero and last set. Grid sizes are
// registers 0..2 (X, Y, Z), reset to 16; values above MAX_DIM act as MAX_DIM
// and a zero size empties the grid. The back end walks all 27 offsets of an
// in-grid query whether each is in the grid or not, pausing while the result
// queue is full, and pops the next queued query as it finishes the last, with
// no gap. The front end splits the index with a shared restoring divider,
// one quotient bit a cycle, and runs on the next query while the back end
// walks. A query passes the input holding register, the divider, the query
// queue, the back end and the result queue. After any register write the
// input reports full while the plane and total products settle.
// There is no clearing pass after reset.
module grid_neighbor_cell_enumerator #(
	parameter int MAX_DIM = gnce_pkg::MAX_DIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// query side
	input  logic                           push,
	output logic                           full,
	input  logic [gnce_pkg::IDX_W-1:0]     cell_index,
	// result side
	output logic                           empty,
	input  logic                           pop,
	output logic [gnce_pkg::IDX_W-1:0]     neighbor_index,
	output logic                           valid_res,
	output logic                           last,
	// register write port
	input  logic                           wr_en,
	input  logic [gnce_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [gnce_pkg::SIZE_W-1:0]    wr_data
);
	import gnce_pkg::*;

	// a 7-bit register never exceeds 127, so that bounds the coordinate width
	localparam int SIZE_MAX  = (1 << SIZE_W) - 1;
	localparam int EFF_MAX   = (MAX_DIM < SIZE_MAX) ? MAX_DIM : SIZE_MAX;
	localparam int DIM_W_RAW = $clog2(EFF_MAX + 1);
	localparam int DIM_W     = (DIM_W_RAW < 2) ? 2 : DIM_W_RAW;
	localparam int PLANE_W   = 2 * DIM_W;
	localparam int TOT_W     = 3 * DIM_W;
	// geometry straight out of reset, already clamped
	localparam int RST_DIM   = (int'(SIZE_RESET) > EFF_MAX) ? EFF_MAX : int'(SIZE_RESET);

	logic [SIZE_W-1:0]  size_x_q, size_y_q, size_z_q;
	logic [1:0]         settle_q;
	logic [DIM_W-1:0]   eff_x, eff_y, eff_z;
	logic [DIM_W-1:0]   nx_q, ny_q, nz_q;
	logic [PLANE_W-1:0] plane_q;
	logic [TOT_W-1:0]   total_q;

	logic fr_push, fr_full;
	logic q_push, q_full, job_empty, job_pop;
	job_t q_job, job_head;
	logic res_push, res_full;
	res_t res_in, res_head;

	// clamp to MAX_DIM
	assign eff_x = (size_x_q > SIZE_W'(EFF_MAX)) ? DIM_W'(EFF_MAX) : DIM_W'(size_x_q);
	assign eff_y = (size_y_q > SIZE_W'(EFF_MAX)) ? DIM_W'(EFF_MAX) : DIM_W'(size_y_q);
	assign eff_z = (size_z_q > SIZE_W'(EFF_MAX)) ? DIM_W'(EFF_MAX) : DIM_W'(size_z_q);

	// settle window covers plane, then total, which is registered from plane
	assign full    = fr_full || (settle_q != '0);
	assign fr_push = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_RESET;
			size_y_q <= SIZE_RESET;
			size_z_q <= SIZE_RESET;
			settle_q <= '0;
		end else begin
			if (wr_en) begin
				settle_q <= CFG_SETTLE;
				case (wr_index)
					REG_SIZE_X: size_x_q <= wr_data;
					REG_SIZE_Y: size_y_q <= wr_data;
					REG_SIZE_Z: size_z_q <= wr_data;
					default: ;
				endcase
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	// derived grid geometry, one multiply per register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q    <= DIM_W'(RST_DIM);
			ny_q    <= DIM_W'(RST_DIM);
			nz_q    <= DIM_W'(RST_DIM);
			plane_q <= PLANE_W'(RST_DIM * RST_DIM);
			total_q <= TOT_W'(RST_DIM * RST_DIM * RST_DIM);
		end else begin
			nx_q    <= eff_x;
			ny_q    <= eff_y;
			nz_q    <= eff_z;
			plane_q <= PLANE_W'(eff_x) * PLANE_W'(eff_y);
			total_q <= TOT_W'(plane_q) * TOT_W'(nz_q);
		end
	end

	gnce_front #(
		.DIM_W (DIM_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_push (fr_push),
		.in_cell (cell_index),
		.in_full (fr_full),
		.nx      (nx_q),
		.ny      (ny_q),
		.nz      (nz_q),
		.plane   (plane_q),
		.total   (total_q),
		.q_push  (q_push),
		.q_job   (q_job),
		.q_full  (q_full)
	);

	// query queue, lets front and back stall independently
	gnce_fifo #(
		.WIDTH ($bits(job_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_job),
		.full    (q_full),
		.rd_en   (job_pop),
		.rd_data (job_head),
		.empty   (job_empty)
	);

	gnce_back #(
		.DIM_W (DIM_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!job_empty),
		.job       (job_head),
		.job_pop   (job_pop),
		.nx        (nx_q),
		.plane     (plane_q),
		.res_push  (res_push),
		.res       (res_in),
		.res_full  (res_full)
	);

	// result queue; the head drives the ports
	gnce_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_head),
		.empty   (empty)
	);

	assign neighbor_index = res_head.idx;
	assign valid_res      = res_head.valid;
	assign last           = res_head.last;

`include "grid_neighbor_cell_enumerator_assert.svh"

	// a register write must hold off input transfers while geometry settles
	`GNCE_ASSERT_NEXT(a_cfg_holds_input, clk, arst_n, wr_en, full)
	// out-of-grid results are a lone, closing, zero-index transfer
	`GNCE_ASSERT_IMPL(a_oob_shape, clk, arst_n, !empty && !valid_res, last && neighbor_index == '0)
	// back end only takes a query that is queued
	`GNCE_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, job_pop, !job_empty)

endmodule

/* design/gnce_fifo.sv */
// Small register FIFO used between front and back and at the output.
// Depends on gnce_pkg for default sizes.
module gnce_fifo #(
	parameter int WIDTH = $bits(gnce_pkg::job_t),
	parameter int DEPTH = gnce_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	import gnce_pkg::*;

	localparam int AW = (DEPTH < 2) ? 1 : $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* design/gnce_front.sv */
// Front end: input holding register, bit-serial split of the index into
// coordinates, and edge classification. Depends on gnce_pkg.
module gnce_front #(
	parameter int DIM_W = gnce_pkg::DIM_W_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_push,
	input  logic [gnce_pkg::IDX_W-1:0] in_cell,
	output logic                       in_full,
	input  logic [DIM_W-1:0]           nx,
	input  logic [DIM_W-1:0]           ny,
	input  logic [DIM_W-1:0]           nz,
	input  logic [2*DIM_W-1:0]         plane,
	input  logic [3*DIM_W-1:0]         total,
	output logic                       q_push,
	output gnce_pkg::job_t             q_job,
	input  logic                       q_full
);
	import gnce_pkg::*;

	localparam int TOT_W = 3 * DIM_W;
	localparam int DIV_W = (IDX_W > TOT_W) ? IDX_W : TOT_W;
	localparam int CNT_W = $clog2(DIM_W);

	front_state_t     state_q, state_d;
	logic             hold_valid_q;
	logic [IDX_W-1:0] hold_cell_q;
	logic [IDX_W-1:0] cell_q;
	logic             oob_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] div_q;
	logic [DIM_W-1:0] quo_q;
	logic [DIM_W-1:0] cz_q;
	logic [CNT_W-1:0] cnt_q;

	logic             load;
	logic             is_oob;
	logic             ge;
	logic [DIM_W-1:0] quo_nx;
	logic             last_bit;
	logic [DIV_W-1:0] z_init;
	logic [DIV_W-1:0] y_init;

	assign is_oob   = DIV_W'(hold_cell_q) >= DIV_W'(total);
	assign ge       = rem_q >= div_q;
	assign quo_nx   = {quo_q[DIM_W-2:0], ge};
	assign last_bit = (cnt_q == '0);
	assign z_init   = DIV_W'(plane) << (DIM_W - 1);
	assign y_init   = DIV_W'(nx) << (DIM_W - 1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_IDLE: begin
				if (hold_valid_q) begin
					state_d = is_oob ? FS_EMIT : FS_DIV_Z;
				end
			end
			FS_DIV_Z: begin
				if (last_bit) begin
					state_d = FS_DIV_Y;
				end
			end
			FS_DIV_Y: begin
				if (last_bit) begin
					state_d = FS_EMIT;
				end
			end
			FS_EMIT: begin
				if (!q_full) begin
					state_d = FS_IDLE;
				end
			end
			default: state_d = FS_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_full = hold_valid_q;
		load    = 1'b0;
		q_push  = 1'b0;
		case (state_q)
			FS_IDLE: load   = hold_valid_q;
			FS_EMIT: q_push = !q_full;
			default: ;
		endcase
	end

	// x is the final remainder, y the second quotient, z the first
	always_comb begin
		q_job.cell_idx = cell_q;
		q_job.oob      = oob_q;
		q_job.lo_x     = (rem_q != '0);
		q_job.hi_x     = (rem_q + DIV_W'(1)) < DIV_W'(nx);
		q_job.lo_y     = (quo_q != '0);
		q_job.hi_y     = ({1'b0, quo_q} + (DIM_W + 1)'(1)) < {1'b0, ny};
		q_job.lo_z     = (cz_q != '0);
		q_job.hi_z     = ({1'b0, cz_q} + (DIM_W + 1)'(1)) < {1'b0, nz};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= FS_IDLE;
			hold_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_push) begin
				hold_valid_q <= 1'b1;
			end else if (load) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_push) begin
			hold_cell_q <= in_cell;
		end
		if (load) begin
			cell_q <= hold_cell_q;
			oob_q  <= is_oob;
			rem_q  <= DIV_W'(hold_cell_q);
			div_q  <= z_init;
			quo_q  <= '0;
			cnt_q  <= CNT_W'(DIM_W - 1);
		end else if (state_q == FS_DIV_Z || state_q == FS_DIV_Y) begin
			if (ge) begin
				rem_q <= rem_q - div_q;
			end
			if (last_bit && state_q == FS_DIV_Z) begin
				cz_q  <= quo_nx;
				quo_q <= '0;
				div_q <= y_init;
				cnt_q <= CNT_W'(DIM_W - 1);
			end else begin
				quo_q <= quo_nx;
				div_q <= div_q >> 1;
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

/* design/gnce_back.sv */
// Back end: walks the 27 offsets of an in-grid query, one per cycle unless a
// result waits on a full queue, and forms neighbour indices by adding strides. Depends on gnce_pkg.
module gnce_back #(
	parameter int DIM_W = gnce_pkg::DIM_W_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   job_valid,
	input  gnce_pkg::job_t         job,
	output logic                   job_pop,
	input  logic [DIM_W-1:0]       nx,
	input  logic [2*DIM_W-1:0]     plane,
	output logic                   res_push,
	output gnce_pkg::res_t         res,
	input  logic                   res_full
);
	import gnce_pkg::*;

	logic             busy_q;
	job_t             job_q;
	ofs_t             dx_q, dy_q, dz_q;
	ofs_t             dx_d, dy_d, dz_d;
	ofs_t             end_x, end_y, end_z;
	logic             in_x, in_y, in_z;
	logic             emit, stall, walk_end, finish;
	logic [IDX_W-1:0] plane_e, nx_e;
	logic [IDX_W-1:0] x_term, y_term, z_term;

	function automatic ofs_t ofs_inc(input ofs_t v);
		ofs_inc = OFS_NEG;
		case (v)
			OFS_NEG: ofs_inc = OFS_MID;
			OFS_MID: ofs_inc = OFS_POS;
			default: ofs_inc = OFS_NEG;
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] stride(input ofs_t v, input logic [IDX_W-1:0] s);
		stride = '0;
		case (v)
			OFS_NEG: stride = IDX_W'(0) - s;
			OFS_POS: stride = s;
			default: stride = '0;
		endcase
	endfunction

	assign in_x = (dx_q != OFS_NEG || job_q.lo_x) && (dx_q != OFS_POS || job_q.hi_x);
	assign in_y = (dy_q != OFS_NEG || job_q.lo_y) && (dy_q != OFS_POS || job_q.hi_y);
	assign in_z = (dz_q != OFS_NEG || job_q.lo_z) && (dz_q != OFS_POS || job_q.hi_z);

	assign end_x = job_q.hi_x ? OFS_POS : OFS_MID;
	assign end_y = job_q.hi_y ? OFS_POS : OFS_MID;
	assign end_z = job_q.hi_z ? OFS_POS : OFS_MID;

	assign walk_end = (dx_q == OFS_POS) && (dy_q == OFS_POS) && (dz_q == OFS_POS);
	assign emit     = busy_q && (job_q.oob || (in_x && in_y && in_z));
	assign stall    = emit && res_full;
	assign finish   = busy_q && !stall && (job_q.oob || walk_end);
	assign job_pop  = job_valid && (!busy_q || finish);
	assign res_push = emit && !res_full;

	// modular sum: true index is in the grid, low bits are exact
	assign plane_e = IDX_W'(plane);
	assign nx_e    = IDX_W'(nx);
	assign x_term  = stride(dx_q, IDX_W'(1));
	assign y_term  = stride(dy_q, nx_e);
	assign z_term  = stride(dz_q, plane_e);

	always_comb begin
		res.idx   = job_q.oob ? '0 : job_q.cell_idx + x_term + y_term + z_term;
		res.valid = !job_q.oob;
		res.last  = job_q.oob || (dx_q == end_x && dy_q == end_y && dz_q == end_z);
	end

	// Z innermost, X outermost
	always_comb begin
		dz_d = ofs_inc(dz_q);
		dy_d = dy_q;
		dx_d = dx_q;
		if (dz_q == OFS_POS) begin
			dy_d = ofs_inc(dy_q);
			if (dy_q == OFS_POS) begin
				dx_d = ofs_inc(dx_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			dx_q   <= OFS_NEG;
			dy_q   <= OFS_NEG;
			dz_q   <= OFS_NEG;
		end else if (job_pop) begin
			busy_q <= 1'b1;
			dx_q   <= OFS_NEG;
			dy_q   <= OFS_NEG;
			dz_q   <= OFS_NEG;
		end else if (finish) begin
			busy_q <= 1'b0;
		end else if (busy_q && !stall) begin
			dx_q <= dx_d;
			dy_q <= dy_d;
			dz_q <= dz_d;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
	end

endmodule

/* tb/sv/grid_neighbor_cell_enumerator_tb.sv */
// Self-checking testbench for grid_neighbor_cell_enumerator.
// Depends on gnce_pkg and the block itself; a scoreboard class predicts the
// neighbour lists, plain tasks drive the query and register ports, a process the result port.
module grid_neighbor_cell_enumerator_tb;
	import gnce_pkg::*;

	// register index past the end of the list; writes to it must be dropped
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

	// first result trails the query through both divisions, then the walk over the offsets follows
	localparam int QUIET_CYCLES = 48;
	localparam int IDLE_PCT     = 37;
	localparam int RAND_PHASES  = 6;
	localparam int PHASE_CELLS  = 28;

	// Predicts, per accepted query, the neighbour indices the block must return
	// and holds them in arrival order until the result port delivers them.
	class neighbor_scoreboard;
		logic [SIZE_W-1:0] dim_reg [3];
		res_t              pending_neighbors [$];
		int unsigned       mismatches;

		function new();
			dim_reg    = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
			mismatches = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] index, logic [SIZE_W-1:0] data);
			case (index)
			REG_SIZE_X: dim_reg[0] = data;
			REG_SIZE_Y: dim_reg[1] = data;
			REG_SIZE_Z: dim_reg[2] = data;
			default: ;
			endcase
		endfunction

		// sizes above MAX_DIM saturate
		function int span(int axis);
			return (dim_reg[axis] > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(dim_reg[axis]);
		endfunction

		function int cell_count();
			return span(0) * span(1) * span(2);
		endfunction

		// query transfer seen: queue its neighbour list
		function void note_query(logic [IDX_W-1:0] cell_id);
			int   nx, ny, nz, plane, total, cx, cy, cz, px, py, pz;
			res_t r;
			nx    = span(0);
			ny    = span(1);
			nz    = span(2);
			plane = nx * ny;
			total = plane * nz;
			if (total == 0 || int'(cell_id) >= total) begin
				r.idx   = '0;
				r.valid = 1'b0;
				r.last  = 1'b1;
				pending_neighbors.push_back(r);
				return;
			end
			cx = (int'(cell_id) % plane) % nx;
			cy = (int'(cell_id) % plane) / nx;
			cz = int'(cell_id) / plane;
			// X outermost, Z innermost, the cell itself included
			for (int dx = -1; dx <= 1; dx++) begin
				for (int dy = -1; dy <= 1; dy++) begin
					for (int dz = -1; dz <= 1; dz++) begin
						px = cx + dx;
						py = cy + dy;
						pz = cz + dz;
						if (px < 0 || px >= nx || py < 0 || py >= ny || pz < 0 || pz >= nz)
							continue;
						r.idx   = IDX_W'(px + py * nx + pz * plane);
						r.valid = 1'b1;
						r.last  = 1'b0;
						pending_neighbors.push_back(r);
					end
				end
			end
			pending_neighbors[pending_neighbors.size() - 1].last = 1'b1;
		endfunction

		// result transfer seen: compare with the oldest prediction
		function void check_neighbor(logic [IDX_W-1:0] idx, logic valid, logic fin);
			res_t want;
			if (pending_neighbors.size() == 0) begin
				$error("unexpected result: neighbor_index %0d valid_res %0b last %0b",
					idx, valid, fin);
				mismatches++;
				return;
			end
			want = pending_neighbors.pop_front();
			if (idx !== want.idx) begin
				$error("neighbor_index: expected %0d, got %0d", want.idx, idx);
				mismatches++;
			end
			if (valid !== want.valid) begin
				$error("valid_res: expected %0b, got %0b", want.valid, valid);
				mismatches++;
			end
			if (fin !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, fin);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic [IDX_W-1:0]     cell_index;
	logic                 empty;
	logic                 pop;
	logic [IDX_W-1:0]     neighbor_index;
	logic                 valid_res;
	logic                 last;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [SIZE_W-1:0]    wr_data;

	neighbor_scoreboard sb;
	// set for a phase that runs with both sides flat out
	bit                 no_gaps;

	grid_neighbor_cell_enumerator u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.cell_index     (cell_index),
		.empty          (empty),
		.pop            (pop),
		.neighbor_index (neighbor_index),
		.valid_res      (valid_res),
		.last           (last),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: pop is redrawn every falling edge, so stalls land on any
	// phase of the back end's walk, including mid-list and on the last entry.
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			pop <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// a result transfer happens on a rising edge with pop high and empty low
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_neighbor(neighbor_index, valid_res, last);
	end

	// Query side. Push may stay high across back-to-back transfers; a gap
	// lowers it for whole cycles. The prediction is noted on the transfer edge.
	task automatic send_cell(input logic [IDX_W-1:0] cell_id);
		@(negedge clk);
		while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push       <= 1'b1;
		cell_index <= cell_id;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_query(cell_id);
	endtask

	// end of a batch: stop pushing and let every outstanding result drain
	task automatic close_batch();
		@(negedge clk);
		push <= 1'b0;
		while (sb.pending_neighbors.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// register writes happen only with the block drained
	task automatic write_size(input logic [REG_IDX_W-1:0] index,
			input logic [SIZE_W-1:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= index;
		wr_data  <= data;
		sb.write_reg(index, data);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_grid(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
			input logic [SIZE_W-1:0] sz);
		write_size(REG_SIZE_X, sx);
		write_size(REG_SIZE_Y, sy);
		write_size(REG_SIZE_Z, sz);
	endtask

	// mostly small grids, now and then a saturating size or an empty axis
	function automatic logic [SIZE_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return SIZE_W'($urandom_range(1, 6));
		else if (r < 16)
			return SIZE_W'($urandom_range(7, 64));
		else if (r < 19)
			return SIZE_W'($urandom_range(65, 127));
		return '0;
	endfunction

	// mostly in-grid cells; some just past the end, some anywhere in 18 bits
	function automatic logic [IDX_W-1:0] pick_cell();
		int total, r;
		total = sb.cell_count();
		r     = $urandom_range(0, 99);
		if (total == 0 || r < 10)
			return IDX_W'($urandom);
		if (r < 16 && total < (1 << IDX_W))
			return IDX_W'(total);
		return IDX_W'($urandom_range(0, total - 1));
	endfunction

	initial begin
		sb         = new();
		no_gaps    = 1'b0;
		arst_n     = 1'b0;
		push       = 1'b0;
		cell_index = '0;
		wr_en      = 1'b0;
		wr_index   = REG_SIZE_X;
		wr_data    = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset grid 16x16x16: corners, interior, first cell beyond,
		// all-ones index and a far out-of-grid index
		send_cell(18'd0);
		send_cell(18'd4095);
		send_cell(18'd273);
		send_cell(18'd15);
		send_cell(18'd240);
		send_cell(18'd3840);
		send_cell(18'd4096);
		send_cell(18'h3FFFF);
		send_cell(18'h20000);
		close_batch();

		// saturating sizes give a full 64^3 grid covering every index;
		// the write to the spare index must leave X alone
		set_grid(7'd127, 7'd64, 7'd100);
		write_size(REG_SPARE, 7'd0);
		send_cell(18'd0);
		send_cell(18'h3FFFF);
		send_cell(18'h2AAAA);
		send_cell(18'h15555);
		send_cell(18'd133152);
		send_cell(18'd63);
		close_batch();

		// single-cell grid: only the cell itself, then out of grid
		set_grid(7'd1, 7'd1, 7'd1);
		send_cell(18'd0);
		send_cell(18'd1);
		send_cell(18'd2);
		close_batch();

		// zero size along Z: grid empty, every index out of grid
		write_size(REG_SIZE_Z, 7'd0);
		send_cell(18'd0);
		send_cell(18'd5);
		close_batch();

		// random phases; one of them with no idling at all on either side
		for (int p = 0; p < RAND_PHASES; p++) begin
			no_gaps = (p == 2);
			set_grid(pick_size(), pick_size(), pick_size());
			if ($urandom_range(0, 2) == 0)
				write_size(REG_SPARE, SIZE_W'($urandom));
			for (int n = 0; n < PHASE_CELLS; n++)
				send_cell(pick_cell());
			close_batch();
		end

		if (sb.mismatches == 0 && sb.pending_neighbors.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

endmodule
